FILE: sv/mbg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbg_pkg
// Shared types, register indexes and helper functions for the escape-time
// glyph pipeline.
// ----------------------------------------------------------------------------
package mbg_pkg;

  localparam int CoordWidth = 32;
  localparam int CountWidth = 5;
  localparam int CfgIdxWidth = 2;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_CENTER_X    = 2'd0,
    REG_CENTER_Y    = 2'd1,
    REG_PIXEL_SCALE = 2'd2
  } cfg_reg_t;

  localparam logic [7:0] GLYPH_NEWLINE = 8'd10;

  // One pixel as it travels down the iteration pipeline.
  typedef struct packed {
    logic signed [CoordWidth-1:0] x;
    logic signed [CoordWidth-1:0] y;
    logic signed [CoordWidth-1:0] cx;
    logic signed [CoordWidth-1:0] cy;
    logic                         done;
    logic [CountWidth-1:0]        count;
    logic                         row_end;
  } pix_t;

  function automatic logic signed [CoordWidth-1:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sh0000_0000_7FFF_FFFF;
    lo = -64'sh0000_0000_8000_0000;
    if (v > hi) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = v[CoordWidth-1:0];
    end
  endfunction

  // Character ramp " ..::--===+++****####%%%%%@@@@@@".
  function automatic logic [7:0] ramp_glyph(input logic [CountWidth-1:0] idx);
    logic [7:0] g;
    case (idx) inside
      5'd0:            g = 8'h20;
      [5'd1:5'd2]:     g = 8'h2E;
      [5'd3:5'd4]:     g = 8'h3A;
      [5'd5:5'd6]:     g = 8'h2D;
      [5'd7:5'd9]:     g = 8'h3D;
      [5'd10:5'd12]:   g = 8'h2B;
      [5'd13:5'd16]:   g = 8'h2A;
      [5'd17:5'd20]:   g = 8'h23;
      [5'd21:5'd25]:   g = 8'h25;
      default:         g = 8'h40;
    endcase
    return g;
  endfunction

endpackage

FILE: sv/mbg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbg_pix_if / mbg_glyph_if
// Valid/ready channels for pixel requests and glyph results.
// ----------------------------------------------------------------------------
interface mbg_pix_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] col_offset;
  logic signed [7:0] row_offset;
  logic              row_end;
  modport source(output valid, col_offset, row_offset, row_end, input ready);
  modport sink(input valid, col_offset, row_offset, row_end, output ready);
endinterface

interface mbg_glyph_if;
  logic       valid;
  logic       ready;
  logic [7:0] glyph;
  logic [4:0] escape_count;
  logic       last;
  modport source(output valid, glyph, escape_count, last, input ready);
  modport sink(input valid, glyph, escape_count, last, output ready);
endinterface

FILE: sv/mbg_iter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbg_iter
// One z = z^2 + c step in two register stages: products, then saturate,
// escape test and update.
// ----------------------------------------------------------------------------
module mbg_iter #(
  parameter int ITER_INDEX = 0,
  parameter int FRAC_BITS  = 24
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  mbg_pkg::pix_t in_pix,
  output logic          out_valid,
  output mbg_pkg::pix_t out_pix
);

  localparam logic signed [32:0] LIMIT = 33'sd4 <<< FRAC_BITS;
  localparam logic [mbg_pkg::CountWidth-1:0] STEP_COUNT =
    (ITER_INDEX > 31) ? 5'd31 : 5'(ITER_INDEX);

  logic               valid_a;
  mbg_pkg::pix_t      pix_a;
  logic signed [63:0] xx_prod;
  logic signed [63:0] yy_prod;
  logic signed [63:0] xy_prod;

  logic signed [31:0] xx;
  logic signed [31:0] yy;
  logic signed [31:0] twoxy;
  logic signed [32:0] mag;
  logic               escape;
  mbg_pkg::pix_t      pix_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
    end else if (en) begin
      valid_a <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pix_a   <= in_pix;
      xx_prod <= 64'(in_pix.x) * 64'(in_pix.x);
      yy_prod <= 64'(in_pix.y) * 64'(in_pix.y);
      xy_prod <= 64'(in_pix.x) * 64'(in_pix.y);
    end
  end

  always_comb begin
    xx     = mbg_pkg::sat32(xx_prod >>> FRAC_BITS);
    yy     = mbg_pkg::sat32(yy_prod >>> FRAC_BITS);
    twoxy  = mbg_pkg::sat32(xy_prod >>> (FRAC_BITS - 1));
    mag    = 33'(xx) + 33'(yy);
    escape = mag > LIMIT;
    pix_next = pix_a;
    if (!pix_a.done) begin
      if (escape) begin
        pix_next.done  = 1'b1;
        pix_next.count = STEP_COUNT;
      end else begin
        pix_next.y = mbg_pkg::sat32(64'(twoxy) + 64'(pix_a.cy));
        pix_next.x = mbg_pkg::sat32(64'(xx) - 64'(yy) + 64'(pix_a.cx));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= valid_a;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_pix <= pix_next;
    end
  end

endmodule

FILE: sv/mandelbrot_escape_time_glyph.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_glyph
// Escape-time glyph generator for a view set by center and scale registers.
// ----------------------------------------------------------------------------
// Usage: software writes center_x, center_y and pixel_scale through the
// cfg_we/cfg_index/cfg_data port while the block is idle, then streams pixel
// offsets on the pix channel. Each pixel yields one glyph result on res; a
// pixel with row_end set yields a second result, the newline, with last set.
// The pixel point is iterated by MAX_ITERATIONS unrolled steps, each a
// multiply stage and an update stage, between the entry register and the
// output register. The pipeline accepts one pixel per cycle while the
// receiver takes results; a newline result holds the pipeline while it is
// sent.
// Reset restores the default view and empties the pipeline. When the
// receiver stalls, the whole pipeline holds and pix.ready drops; nothing is
// lost or repeated.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_glyph #(
  parameter int MAX_ITERATIONS  = 32,
  parameter int COORD_FRAC_BITS = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [mbg_pkg::CfgIdxWidth-1:0]     cfg_index,
  input  logic [mbg_pkg::CoordWidth-1:0]      cfg_data,
  mbg_pix_if.sink                             pix,
  mbg_glyph_if.source                         res
);

  logic signed [31:0] center_x;
  logic signed [31:0] center_y;
  logic [30:0]        pixel_scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x    <= -32'sd8388608;
      center_y    <= 32'sd0;
      pixel_scale <= 31'd4194304;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mbg_pkg::REG_CENTER_X:    center_x    <= cfg_data;
        mbg_pkg::REG_CENTER_Y:    center_y    <= cfg_data;
        mbg_pkg::REG_PIXEL_SCALE: pixel_scale <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  logic advance;
  logic nl_pending;

  // Entry stage: map the pixel offset into the complex plane.
  logic signed [39:0] col_prod;
  logic signed [39:0] row_prod;
  mbg_pkg::pix_t      entry_pix;
  logic               entry_valid;
  mbg_pkg::pix_t      entry_next;

  always_comb begin
    col_prod = 40'(pix.col_offset) * $signed({9'd0, pixel_scale});
    row_prod = 40'(pix.row_offset) * $signed({9'd0, pixel_scale});
    entry_next.x       = '0;
    entry_next.y       = '0;
    entry_next.cx      = mbg_pkg::sat32(64'(center_x) + 64'(col_prod));
    entry_next.cy      = mbg_pkg::sat32(64'(center_y) + 64'(row_prod));
    entry_next.done    = 1'b0;
    entry_next.count   = '0;
    entry_next.row_end = pix.row_end;
  end

  assign pix.ready = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= 1'b0;
    end else if (advance) begin
      entry_valid <= pix.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      entry_pix <= entry_next;
    end
  end

  logic          chain_valid [MAX_ITERATIONS+1];
  mbg_pkg::pix_t chain_pix   [MAX_ITERATIONS+1];

  assign chain_valid[0] = entry_valid;
  assign chain_pix[0]   = entry_pix;

  for (genvar i = 0; i < MAX_ITERATIONS; i++) begin : g_iter
    mbg_iter #(
      .ITER_INDEX(i),
      .FRAC_BITS (COORD_FRAC_BITS)
    ) u_iter (
      .clk      (clk),
      .rst      (rst),
      .en       (advance),
      .in_valid (chain_valid[i]),
      .in_pix   (chain_pix[i]),
      .out_valid(chain_valid[i+1]),
      .out_pix  (chain_pix[i+1])
    );
  end

  // Output register; a pending newline is sent after the glyph it follows.
  mbg_pkg::pix_t tail;
  logic          res_fire;

  assign tail     = chain_pix[MAX_ITERATIONS];
  assign res_fire = res.valid && res.ready;
  assign advance  = !res.valid || (res.ready && !nl_pending);

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid  <= 1'b0;
      nl_pending <= 1'b0;
    end else if (res_fire && nl_pending) begin
      nl_pending <= 1'b0;
    end else if (advance) begin
      res.valid  <= chain_valid[MAX_ITERATIONS];
      nl_pending <= chain_valid[MAX_ITERATIONS] && tail.row_end;
    end
  end

  always_ff @(posedge clk) begin
    if (res_fire && nl_pending) begin
      res.glyph        <= mbg_pkg::GLYPH_NEWLINE;
      res.escape_count <= '0;
      res.last         <= 1'b1;
    end else if (advance) begin
      res.glyph        <= mbg_pkg::ramp_glyph(tail.count);
      res.escape_count <= tail.count;
      res.last         <= !tail.row_end;
    end
  end

endmodule

FILE: sv/mbg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbg_checker
// Port-level checks on the glyph result stream.
// ----------------------------------------------------------------------------
module mbg_checker (
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_ready,
  input logic [7:0] res_glyph,
  input logic [4:0] res_escape_count,
  input logic       res_last
);

  // A glyph that is not last is followed at once by its newline.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready && !res_last |=>
      res_valid && res_glyph == mbg_pkg::GLYPH_NEWLINE && res_last)
    else $error("newline did not follow a non-final glyph");

  assert property (@(posedge clk) disable iff (rst)
    res_valid && res_glyph == mbg_pkg::GLYPH_NEWLINE |->
      res_escape_count == 5'd0 && res_last)
    else $error("newline result carries a count or is not last");

  assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_glyph) && $stable(res_last))
    else $error("stalled result changed");

endmodule

bind mandelbrot_escape_time_glyph mbg_checker u_mbg_checker (
  .clk             (clk),
  .rst             (rst),
  .res_valid       (res.valid),
  .res_ready       (res.ready),
  .res_glyph       (res.glyph),
  .res_escape_count(res.escape_count),
  .res_last        (res.last)
);
